// ===== rtl/fpa_pkg.sv =====
// Shared operation codes and item types for the fixed-point ALU.
package fpa_pkg;

  localparam logic [3:0] OP_ADD   = 4'd0;
  localparam logic [3:0] OP_SUB   = 4'd1;
  localparam logic [3:0] OP_MUL   = 4'd2;
  localparam logic [3:0] OP_DIV   = 4'd3;
  localparam logic [3:0] OP_GT    = 4'd4;
  localparam logic [3:0] OP_LT    = 4'd5;
  localparam logic [3:0] OP_GE    = 4'd6;
  localparam logic [3:0] OP_LE    = 4'd7;
  localparam logic [3:0] OP_EQ    = 4'd8;
  localparam logic [3:0] OP_NE    = 4'd9;
  localparam logic [3:0] OP_MIN   = 4'd10;
  localparam logic [3:0] OP_MAX   = 4'd11;
  localparam logic [3:0] OP_INC   = 4'd12;
  localparam logic [3:0] OP_DEC   = 4'd13;
  localparam logic [3:0] OP_TOINT = 4'd14;

  localparam int IO_BITS = 32;

  // Result side flags carried down the cell chain.
  typedef struct packed {
    logic compare_true;
    logic divide_by_zero;
  } flags_t;

endpackage

// ===== rtl/fpa_cell.sv =====
// One restoring-division step cell; also forwards the item down the chain.
module fpa_cell #(
  parameter int WB = 32,
  parameter int DW = 80
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [DW-1:0]    in_rem,
  input  logic [DW-1:0]    in_num,
  input  logic [DW-1:0]    in_den,
  input  logic [WB-1:0]    in_quo,
  input  logic [WB+5:0]    in_side,
  output logic             out_valid,
  output logic [DW-1:0]    out_rem,
  output logic [DW-1:0]    out_num,
  output logic [DW-1:0]    out_den,
  output logic [WB-1:0]    out_quo,
  output logic [WB+5:0]    out_side
);

  logic [DW-1:0] trial;
  logic [DW:0]   diff;

  always_comb begin
    trial = {in_rem[DW-2:0], in_num[DW-1]};
    diff  = {1'b0, trial} - {1'b0, in_den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_rem  <= diff[DW] ? trial : diff[DW-1:0];
      out_num  <= {in_num[DW-2:0], 1'b0};
      out_den  <= in_den;
      out_quo  <= {in_quo[WB-2:0], ~diff[DW]};
      out_side <= in_side;
    end
  end

endmodule

// ===== rtl/fixed_point_alu.sv =====
// Top level of the pipelined signed fixed-point ALU.
//
// Accepts one item every cycle while the output is not stalled, and returns
// one result per item, in order. Each item passes the stage 0 register, a
// chain of DW restoring-division cells, one quotient bit per cell, where
// DW = 2*WORD_BITS+FRACTION_BITS+8, and then the output register. The
// multiplier sits in the first stage; every other operation rides the same
// chain so results stay in order. The whole chain stalls when the output
// register is full and not taken.
module fixed_point_alu #(
  parameter int FRACTION_BITS = 8,
  parameter int WORD_BITS     = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // operation[3:0], operand_a[35:4], operand_b[67:36]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata   // result_value[31:0], compare_true[32], divide_by_zero[33]
);

  localparam int WB = WORD_BITS;
  localparam int FB = FRACTION_BITS;
  localparam int DW = 2 * WB + FB + 8;
  localparam int PW = 2 * WB;
  localparam int SW = WB + 6;
  localparam int IOB = fpa_pkg::IO_BITS;

  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic [3:0]      op_in;
  logic [WB-1:0]   a_in, b_in;
  assign op_in = s_axis_tdata[3:0];
  assign a_in  = WB'($signed(s_axis_tdata[35:4]));
  assign b_in  = WB'($signed(s_axis_tdata[67:36]));

  // Stage 0: operand decode, magnitudes, simple ops, product.
  logic [WB-1:0]  ma, mb;
  logic           neg;
  logic [WB-1:0]  simple;
  fpa_pkg::flags_t fl;
  logic           lt_ab, lt_ba;

  always_comb begin
    ma = a_in[WB-1] ? -a_in : a_in;
    mb = b_in[WB-1] ? -b_in : b_in;
    neg = a_in[WB-1] ^ b_in[WB-1];
    lt_ab = $signed(a_in) < $signed(b_in);
    lt_ba = $signed(b_in) < $signed(a_in);
    simple = '0;
    fl = '0;
    case (op_in)
      fpa_pkg::OP_ADD:   simple = a_in + b_in;
      fpa_pkg::OP_SUB:   simple = a_in - b_in;
      fpa_pkg::OP_DIV:   fl.divide_by_zero = (b_in == '0);
      fpa_pkg::OP_GT:    fl.compare_true = lt_ba;
      fpa_pkg::OP_LT:    fl.compare_true = lt_ab;
      fpa_pkg::OP_GE:    fl.compare_true = !lt_ab;
      fpa_pkg::OP_LE:    fl.compare_true = !lt_ba;
      fpa_pkg::OP_EQ:    fl.compare_true = (a_in == b_in);
      fpa_pkg::OP_NE:    fl.compare_true = (a_in != b_in);
      fpa_pkg::OP_MIN:   simple = lt_ab ? a_in : b_in;
      fpa_pkg::OP_MAX:   simple = lt_ba ? a_in : b_in;
      fpa_pkg::OP_INC:   simple = a_in + WB'(1);
      fpa_pkg::OP_DEC:   simple = a_in - WB'(1);
      fpa_pkg::OP_TOINT: simple = WB'($signed(a_in) >>> FB);
      default:           simple = '0;
    endcase
  end

  logic           v1;
  logic [3:0]     op1;
  logic           neg1;
  logic [WB-1:0]  simple1;
  fpa_pkg::flags_t fl1;
  logic [PW-1:0]  prod1;
  logic [DW-1:0]  num1, den1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_axis_tvalid;
    end
    if (en) begin
      op1     <= op_in;
      neg1    <= neg;
      simple1 <= simple;
      fl1     <= fl;
      prod1   <= PW'(ma) * PW'(mb);
      num1    <= (DW'(ma) << (FB + 1)) + DW'(mb);
      den1    <= DW'(mb) << 1;
    end
  end

  // Multiply rounding, carried alongside the divider chain.
  logic [PW:0]    prod_r;
  logic [WB-1:0]  mulm;
  assign prod_r = {1'b0, prod1} + ((PW + 1)'(1) << (FB - 1));
  assign mulm   = prod_r[FB +: WB];

  logic [SW-1:0] side1;
  always_comb begin
    side1 = '0;
    side1[WB-1:0] = (op1 == fpa_pkg::OP_MUL) ? (neg1 ? -mulm : mulm) : simple1;
    side1[WB]     = fl1.compare_true;
    side1[WB+1]   = fl1.divide_by_zero;
    side1[WB+2]   = neg1;
    side1[WB+3]   = (op1 == fpa_pkg::OP_DIV) && !fl1.divide_by_zero;
  end

  logic           cv   [DW+1];
  logic [DW-1:0]  crem [DW+1];
  logic [DW-1:0]  cnum [DW+1];
  logic [DW-1:0]  cden [DW+1];
  logic [WB-1:0]  cquo [DW+1];
  logic [SW-1:0]  cside[DW+1];

  assign cv[0]    = v1;
  assign crem[0]  = '0;
  assign cnum[0]  = num1;
  assign cden[0]  = den1;
  assign cquo[0]  = '0;
  assign cside[0] = side1;

  for (genvar i = 0; i < DW; i++) begin : g_cell
    fpa_cell #(.WB(WB), .DW(DW)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_valid(cv[i]), .in_rem(crem[i]), .in_num(cnum[i]), .in_den(cden[i]),
      .in_quo(cquo[i]), .in_side(cside[i]),
      .out_valid(cv[i+1]), .out_rem(crem[i+1]), .out_num(cnum[i+1]),
      .out_den(cden[i+1]), .out_quo(cquo[i+1]), .out_side(cside[i+1])
    );
  end

  logic [SW-1:0] se;
  logic [WB-1:0] q, res;
  assign se = cside[DW];
  assign q  = cquo[DW];
  assign res = se[WB+3] ? (se[WB+2] ? -q : q) : se[WB-1:0];

  logic [IOB-1:0] res_out;
  assign res_out = IOB'($signed(res));

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= cv[DW];
    end
    if (en) begin
      m_axis_tdata <= {6'd0, se[WB+1], se[WB], res_out};
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench for the fixed-point ALU: directed and random items, result checking.
`timescale 1ns / 1ps

module tb_top;

  localparam int FRAC = 8;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [31:0] value;
    logic        cmp;
    logic        dz;
  } alu_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  alu_result_t expected_q[$];
  int          n_errors = 0;
  int          n_sent = 0;
  int          n_checked = 0;
  bit          quiet_sink = 1'b0;
  bit          use_gaps = 1'b1;
  int          idle_cycles = 0;

  fixed_point_alu dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #5 clk = ~clk;

  // Magnitude-based rounding, ties away from zero.
  function automatic logic [31:0] fx_product(logic signed [31:0] a, logic signed [31:0] b);
    logic [63:0] ma, mb;
    logic [127:0] p;
    logic [127:0] m;
    ma = a[31] ? 64'(-65'(a)) : 64'(a);
    mb = b[31] ? 64'(-65'(b)) : 64'(b);
    p = ma * mb + (128'd1 << (FRAC - 1));
    m = p >> FRAC;
    if (a[31] != b[31]) m = -m;
    return m[31:0];
  endfunction

  function automatic logic [31:0] fx_quotient(logic signed [31:0] a, logic signed [31:0] b);
    logic [63:0] ma, mb;
    logic [127:0] num, q;
    ma = a[31] ? 64'(-65'(a)) : 64'(a);
    mb = b[31] ? 64'(-65'(b)) : 64'(b);
    num = ((128'(ma) << FRAC) << 1) + 128'(mb);
    q = num / (128'(mb) << 1);
    if (a[31] != b[31]) q = -q;
    return q[31:0];
  endfunction

  function automatic alu_result_t alu_expect(logic [3:0] op, logic signed [31:0] a,
                                             logic signed [31:0] b);
    alu_result_t r;
    r = '0;
    case (op)
      fpa_pkg::OP_ADD:   r.value = a + b;
      fpa_pkg::OP_SUB:   r.value = a - b;
      fpa_pkg::OP_MUL:   r.value = fx_product(a, b);
      fpa_pkg::OP_DIV: begin
        if (b == 0) r.dz = 1'b1;
        else r.value = fx_quotient(a, b);
      end
      fpa_pkg::OP_GT:    r.cmp = a > b;
      fpa_pkg::OP_LT:    r.cmp = a < b;
      fpa_pkg::OP_GE:    r.cmp = a >= b;
      fpa_pkg::OP_LE:    r.cmp = a <= b;
      fpa_pkg::OP_EQ:    r.cmp = a == b;
      fpa_pkg::OP_NE:    r.cmp = a != b;
      fpa_pkg::OP_MIN:   r.value = (a < b) ? a : b;
      fpa_pkg::OP_MAX:   r.value = (a > b) ? a : b;
      fpa_pkg::OP_INC:   r.value = a + 1;
      fpa_pkg::OP_DEC:   r.value = a - 1;
      fpa_pkg::OP_TOINT: r.value = a >>> FRAC;
      default:           r = '0;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h (result %0d)", what, got, want, n_checked);
    n_errors++;
  endtask

  task automatic send_item(logic [3:0] op, logic [31:0] a, logic [31:0] b);
    int gap;
    if (use_gaps && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, b, a, op};
    expected_q.push_back(alu_expect(op, a, b));
    n_sent++;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic finish_sending();
    s_axis_tvalid <= 1'b0;
  endtask

  // Sink: random stall bursts.
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      if (!quiet_sink && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 9);
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    alu_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected item", m_axis_tdata[31:0], 32'h0);
      end else begin
        want = expected_q.pop_front();
        if (m_axis_tdata[31:0] !== want.value)
          report_mismatch("result_value", m_axis_tdata[31:0], want.value);
        if (m_axis_tdata[32] !== want.cmp)
          report_mismatch("compare_true", 32'(m_axis_tdata[32]), 32'(want.cmp));
        if (m_axis_tdata[33] !== want.dz)
          report_mismatch("divide_by_zero", 32'(m_axis_tdata[33]), 32'(want.dz));
      end
      n_checked++;
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress, %0d results pending", expected_q.size());
      $display("FAIL fixed_point_alu");
      $finish;
    end
  end

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($signed($urandom_range(0, 2047)) - 1024);
      3: return 32'($urandom_range(0, 255)) << 8;
      4: return -(32'($urandom_range(0, 65535)));
      5: return 32'($urandom_range(0, 65535));
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    logic [31:0] edges[6];
    edges = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h100, 32'h80};
    for (int op = 0; op < 16; op++)
      send_item(op[3:0], edges[op % 6], edges[(op + 1) % 6]);
    send_item(fpa_pkg::OP_DIV, 32'h100, 32'h0);
    send_item(fpa_pkg::OP_DIV, 32'h8000_0000, 32'hffff_ff00);
    send_item(fpa_pkg::OP_MUL, 32'h80, 32'h1);
    send_item(fpa_pkg::OP_MUL, 32'hffff_ff80, 32'h1);
    send_item(fpa_pkg::OP_MIN, 32'h55, 32'h55);
    send_item(fpa_pkg::OP_MAX, 32'h8000_0000, 32'h8000_0000);
    send_item(fpa_pkg::OP_TOINT, 32'hffff_ff01, 32'h0);
    send_item(fpa_pkg::OP_DIV, 32'h300, 32'h200);
    send_item(fpa_pkg::OP_EQ, 32'hffff_ffff, 32'hffff_ffff);
  endtask

  task automatic test_random(int count);
    logic [31:0] a, b;
    logic [3:0]  op;
    for (int i = 0; i < count; i++) begin
      op = 4'($urandom_range(0, 15));
      a = pick_operand();
      b = ($urandom_range(0, 9) == 0) ? a : pick_operand();
      if (op == fpa_pkg::OP_DIV && $urandom_range(0, 12) == 0) b = 0;
      send_item(op, a, b);
    end
  endtask

  task automatic test_back_to_back(int count);
    use_gaps = 1'b0;
    quiet_sink = 1'b1;
    test_random(count);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(900);
    test_back_to_back(250);
    finish_sending();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    $display("covered %0d items over all 16 operation codes, %0d results checked",
             n_sent, n_checked);
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("PASS fixed_point_alu");
    end else begin
      $display("FAIL fixed_point_alu");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/fpa_pkg.sv
rtl/fpa_cell.sv
rtl/fixed_point_alu.sv
tb/tb_top.sv
